@@ hdl/baro_pressure_temp_compensation_top_macros.svh @@
// Assertion macros used by the barometer compensation top level.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is low
`define BPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check, active through reset as well
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/bpc_pkg.sv @@
// Package: constants, register indexes and helpers for barometer compensation.
package bpc_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int UT_W       = 16;
    localparam int UP_W       = 19;
    localparam int TEMP_W     = 16;
    localparam int PRESS_W    = 20;
    localparam int OSS_W      = 2;
    localparam int DIV_SIDE_W = 1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AC1_AC2      = 3'd0,
        CFG_AC3_AC4      = 3'd1,
        CFG_AC5_AC6      = 3'd2,
        CFG_B1_B2        = 3'd3,
        CFG_MC_MD        = 3'd4,
        CFG_OVERSAMPLING = 3'd5
    } t_cfg_idx;

    localparam logic [OSS_W-1:0]  OSS_RESET   = 2'd3;
    localparam logic [DATA_W-1:0] B6_OFFSET   = 32'd4000;
    localparam logic [DATA_W-1:0] B4_BIAS     = 32'd32768;
    localparam logic [DATA_W-1:0] PRESS_SCALE = 32'd50000;
    localparam logic [DATA_W-1:0] K_SQ        = 32'd3038;
    localparam logic [DATA_W-1:0] K_LIN       = 32'hFFFF_E343;  // -7357
    localparam logic [DATA_W-1:0] K_OFS       = 32'd3791;
    localparam logic [DATA_W-1:0] TEMP_ROUND  = 32'd8;
    localparam logic [DATA_W-1:0] B3_ROUND    = 32'd2;
    localparam logic [DATA_W-1:0] PRESS_MAX   = 32'd1048575;
    localparam logic [DATA_W-1:0] TEMP_MAX    = 32'd32767;
    localparam logic [DATA_W-1:0] TEMP_MIN    = 32'hFFFF_8000;

    // Arithmetic right shift of a 32-bit word
    function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] v, input int s);
        return DATA_W'($signed(v) >>> s);
    endfunction

    // Sign-extend a 16-bit half word
    function automatic logic [DATA_W-1:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

@@ hdl/bpc_in_if.sv @@
// Input channel: one raw temperature and raw pressure pair per transfer.
interface bpc_in_if;
    logic                           valid;
    logic                           ready;
    logic [bpc_pkg::UT_W-1:0]       raw_temperature;
    logic [bpc_pkg::UP_W-1:0]       raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

@@ hdl/bpc_out_if.sv @@
// Output channel: compensated temperature, pressure and divide error flag.
interface bpc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bpc_pkg::TEMP_W-1:0]  temperature_tenths;
    logic [bpc_pkg::PRESS_W-1:0]        pressure_pa;
    logic                               divide_error;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output divide_error, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure_pa,
                    input divide_error, output ready);
endinterface

@@ hdl/baro_pressure_temp_compensation_top.sv @@
// Top level: pipelined barometer temperature and pressure compensation.
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        raw_temperature[15:0], raw_pressure[18:0]
//  o_out    out  valid/ready        temperature_tenths[15:0] s, pressure_pa[19:0],
//                                   divide_error
//  i_cfg_*  in   write enable only  i_cfg_idx[2:0], i_cfg_wr_data[31:0]
//
// One item per cycle while o_out is not stalled; 77 register stages from input to output.
// The depth is set by the two 33-stage divider pipelines (temperature and pressure).
// All stages advance together; a result held at o_out stalls the whole pipe and
// i_in.ready drops, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the calibration reset values.
module baro_pressure_temp_compensation_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpc_pkg::DATA_W-1:0]    i_cfg_wr_data,
    bpc_in_if.sink                        i_in,
    bpc_out_if.source                     o_out
);
`include "baro_pressure_temp_compensation_top_macros.svh"

    localparam int W      = bpc_pkg::DATA_W;
    localparam int SIDE1W = W + bpc_pkg::UP_W + 2;
    localparam int SIDE2W = W + 2;

    // Configuration registers
    logic [W-1:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    logic [bpc_pkg::OSS_W-1:0] r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= bpc_pkg::OSS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (bpc_pkg::t_cfg_idx'(i_cfg_idx))
                bpc_pkg::CFG_AC1_AC2:      r_ac1_ac2 <= i_cfg_wr_data;
                bpc_pkg::CFG_AC3_AC4:      r_ac3_ac4 <= i_cfg_wr_data;
                bpc_pkg::CFG_AC5_AC6:      r_ac5_ac6 <= i_cfg_wr_data;
                bpc_pkg::CFG_B1_B2:        r_b1_b2   <= i_cfg_wr_data;
                bpc_pkg::CFG_MC_MD:        r_mc_md   <= i_cfg_wr_data;
                bpc_pkg::CFG_OVERSAMPLING: r_oss     <= i_cfg_wr_data[bpc_pkg::OSS_W-1:0];
                default: ;
            endcase
        end
    end

    // Decoded coefficients
    logic [W-1:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_b1, w_b2, w_mc, w_md;
    assign w_ac1 = bpc_pkg::sx16(r_ac1_ac2[31:16]);
    assign w_ac2 = bpc_pkg::sx16(r_ac1_ac2[15:0]);
    assign w_ac3 = bpc_pkg::sx16(r_ac3_ac4[31:16]);
    assign w_ac4 = {16'b0, r_ac3_ac4[15:0]};
    assign w_ac5 = {16'b0, r_ac5_ac6[31:16]};
    assign w_ac6 = {16'b0, r_ac5_ac6[15:0]};
    assign w_b1  = bpc_pkg::sx16(r_b1_b2[31:16]);
    assign w_b2  = bpc_pkg::sx16(r_b1_b2[15:0]);
    assign w_mc  = bpc_pkg::sx16(r_mc_md[31:16]);
    assign w_md  = bpc_pkg::sx16(r_mc_md[15:0]);

    // Pipeline advance
    logic r_ov;
    logic w_en;
    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    // Valid bits of the top-level stages
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;
    logic w_d1_valid, w_d2_valid;

    // Stage 1: capture raw words
    logic [bpc_pkg::UT_W-1:0] r1_ut;
    logic [bpc_pkg::UP_W-1:0] r1_up;
    // Stage 2: X1
    logic [W-1:0] r2_x1;
    logic [bpc_pkg::UP_W-1:0] r2_up;
    // Divider 1 feed
    logic [W-1:0] w_div, w_num1, w_ma, w_mb;
    logic w_na, w_nb;
    logic [W-1:0] w_q1;
    logic [SIDE1W-1:0] w_side1_in, w_side1_out;
    // Stage 3..8
    logic [W-1:0] r3_b5, r4_b5, r4_b6, r5_b5, r5_psq, r5_pa2, r5_pa3;
    logic [W-1:0] r6_b5, r6_mb2, r6_mb1, r6_x2a, r6_x1c;
    logic [W-1:0] r7_b5, r7_b3, r7_t, r8_b5, r8_b4, r8_b7;
    logic [bpc_pkg::UP_W-1:0] r3_up, r4_up, r5_up, r6_up, r7_up;
    logic r3_dz, r4_dz, r5_dz, r6_dz, r7_dz, r8_dz;
    // Divider 2 and tail
    logic [W-1:0] w_num2, w_q2, w_p;
    logic [SIDE2W-1:0] w_side2_in, w_side2_out;
    logic [W-1:0] r9_m, r9_m2, r9_p, r9_b5, r10_m3, r10_x2, r10_p, r10_b5;
    logic r9_dz, r10_dz;

    // Stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0; r_v9 <= 1'b0; r_v10 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1  <= i_in.valid;
            r_v2  <= r_v1;
            r_v3  <= w_d1_valid;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= w_d2_valid;
            r_v10 <= r_v9;
            r_ov  <= r_v10;
        end
    end

    // Front: X1 = (UT - AC6) * AC5 >> 15
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ut <= i_in.raw_temperature;
            r1_up <= i_in.raw_pressure;
            r2_x1 <= bpc_pkg::asr(({16'b0, r1_ut} - w_ac6) * w_ac5, 15);
            r2_up <= r1_up;
        end
    end

    // Signed division MC*2048 / (X1+MD) by magnitudes
    assign w_div      = r2_x1 + w_md;
    assign w_num1     = {w_mc[W-12:0], 11'b0};
    assign w_na       = w_num1[W-1];
    assign w_nb       = w_div[W-1];
    assign w_ma       = w_na ? (W'(0) - w_num1) : w_num1;
    assign w_mb       = w_nb ? (W'(0) - w_div) : w_div;
    assign w_side1_in = {r2_x1, r2_up, w_na ^ w_nb, (w_div == '0)};

    bpc_div #(.SIDE_W(SIDE1W)) u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_num   (w_ma),
        .i_den   (w_mb),
        .i_side  (w_side1_in),
        .o_valid (w_d1_valid),
        .o_quo   (w_q1),
        .o_side  (w_side1_out)
    );

    // Middle: B5, B6, products, B3, B4, B7
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // B5 = X1 + X2
            r3_b5 <= w_side1_out[SIDE1W-1 -: W]
                   + (w_side1_out[1] ? (W'(0) - w_q1) : w_q1);
            r3_up <= w_side1_out[bpc_pkg::UP_W+1:2];
            r3_dz <= w_side1_out[0];
            // B6
            r4_b5 <= r3_b5;
            r4_b6 <= r3_b5 - bpc_pkg::B6_OFFSET;
            r4_up <= r3_up;
            r4_dz <= r3_dz;
            // First products of B6
            r5_b5  <= r4_b5;
            r5_psq <= r4_b6 * r4_b6;
            r5_pa2 <= w_ac2 * r4_b6;
            r5_pa3 <= w_ac3 * r4_b6;
            r5_up  <= r4_up;
            r5_dz  <= r4_dz;
            // Products of the square term
            r6_b5  <= r5_b5;
            r6_mb2 <= w_b2 * bpc_pkg::asr(r5_psq, 12);
            r6_mb1 <= w_b1 * bpc_pkg::asr(r5_psq, 12);
            r6_x2a <= bpc_pkg::asr(r5_pa2, 11);
            r6_x1c <= bpc_pkg::asr(r5_pa3, 13);
            r6_up  <= r5_up;
            r6_dz  <= r5_dz;
            // B3 and the B4 factor
            r7_b5 <= r6_b5;
            r7_b3 <= bpc_pkg::asr((({w_ac1[W-3:0], 2'b0}
                     + bpc_pkg::asr(r6_mb2, 11) + r6_x2a) << r_oss) + bpc_pkg::B3_ROUND, 2);
            r7_t  <= bpc_pkg::asr(r6_x1c + bpc_pkg::asr(r6_mb1, 16) + bpc_pkg::B3_ROUND, 2)
                   + bpc_pkg::B4_BIAS;
            r7_up <= r6_up;
            r7_dz <= r6_dz;
            // B4 and B7
            r8_b5 <= r7_b5;
            r8_b4 <= (w_ac4 * r7_t) >> 15;
            r8_b7 <= ({13'b0, r7_up} - r7_b3) * (bpc_pkg::PRESS_SCALE >> r_oss);
            r8_dz <= r7_dz;
        end
    end

    // Unsigned division of B7 by B4
    assign w_num2     = r8_b7[W-1] ? r8_b7 : {r8_b7[W-2:0], 1'b0};
    assign w_side2_in = {r8_b5, r8_dz || (r8_b4 == '0), r8_b7[W-1]};

    bpc_div #(.SIDE_W(SIDE2W)) u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v8),
        .i_num   (w_num2),
        .i_den   (r8_b4),
        .i_side  (w_side2_in),
        .o_valid (w_d2_valid),
        .o_quo   (w_q2),
        .o_side  (w_side2_out)
    );

    assign w_p = w_side2_out[0] ? {w_q2[W-2:0], 1'b0} : w_q2;

    // Tail: pressure correction terms
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_m   <= bpc_pkg::asr(w_p, 8) * bpc_pkg::asr(w_p, 8);
            r9_m2  <= bpc_pkg::K_LIN * w_p;
            r9_p   <= w_p;
            r9_b5  <= w_side2_out[SIDE2W-1 -: W];
            r9_dz  <= w_side2_out[1];
            r10_m3 <= r9_m * bpc_pkg::K_SQ;
            r10_x2 <= bpc_pkg::asr(r9_m2, 16);
            r10_p  <= r9_p;
            r10_b5 <= r9_b5;
            r10_dz <= r9_dz;
        end
    end

    // Final sum and saturation
    logic [W-1:0] w_comp, w_t;
    logic signed [bpc_pkg::TEMP_W-1:0] w_temp_sat;
    logic [bpc_pkg::PRESS_W-1:0] w_press_sat;

    assign w_comp = r10_p + bpc_pkg::asr(bpc_pkg::asr(r10_m3, 16) + r10_x2 + bpc_pkg::K_OFS, 4);
    assign w_t    = bpc_pkg::asr(r10_b5 + bpc_pkg::TEMP_ROUND, 4);

    always_comb begin
        if ($signed(w_t) > $signed(bpc_pkg::TEMP_MAX)) begin
            w_temp_sat = bpc_pkg::TEMP_MAX[bpc_pkg::TEMP_W-1:0];
        end else if ($signed(w_t) < $signed(bpc_pkg::TEMP_MIN)) begin
            w_temp_sat = bpc_pkg::TEMP_MIN[bpc_pkg::TEMP_W-1:0];
        end else begin
            w_temp_sat = w_t[bpc_pkg::TEMP_W-1:0];
        end
        if (w_comp[W-1]) begin
            w_press_sat = '0;
        end else if (w_comp > bpc_pkg::PRESS_MAX) begin
            w_press_sat = bpc_pkg::PRESS_MAX[bpc_pkg::PRESS_W-1:0];
        end else begin
            w_press_sat = w_comp[bpc_pkg::PRESS_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out.temperature_tenths <= r10_dz ? '0 : w_temp_sat;
            o_out.pressure_pa        <= r10_dz ? '0 : w_press_sat;
            o_out.divide_error       <= r10_dz;
        end
    end

    assign o_out.valid = r_ov;

    `BPC_ASSERT(a_err_zero, i_clk, i_rst_n, (o_out.valid && o_out.divide_error) |-> (o_out.temperature_tenths == '0 && o_out.pressure_pa == '0), "divide error result not zero")
    `BPC_ASSERT(a_ready_empty, i_clk, i_rst_n, !r_ov |-> i_in.ready, "input stalled with empty output")
    `BPC_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (!o_out.valid && !r_v1), "valid survived reset")

endmodule

@@ hdl/bpc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
module bpc_div #(
    parameter int SIDE_W = bpc_pkg::DIV_SIDE_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [bpc_pkg::DATA_W-1:0] i_num,
    input  logic [bpc_pkg::DATA_W-1:0] i_den,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [bpc_pkg::DATA_W-1:0] o_quo,
    output logic [SIDE_W-1:0]          o_side
);
    localparam int N = bpc_pkg::DATA_W;

    logic         r_vld  [0:N];
    logic [N-1:0] r_rem  [0:N];
    logic [N-1:0] r_num  [0:N];
    logic [N-1:0] r_den  [0:N];
    logic [N-1:0] r_quo  [0:N];
    logic [SIDE_W-1:0] r_side [0:N];

    // Load the first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_num[0]  <= i_num;
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    // One trial subtraction per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N:0]   n_trial;
        logic [N:0]   n_diff;
        logic         n_ge;

        assign n_trial = {r_rem[k], r_num[k][N-1]};
        assign n_diff  = n_trial - {1'b0, r_den[k]};
        assign n_ge    = (n_trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? n_diff[N-1:0] : n_trial[N-1:0];
                r_quo[k+1]  <= {r_quo[k][N-2:0], n_ge};
                r_num[k+1]  <= {r_num[k][N-2:0], 1'b0};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_quo   = r_quo[N];
    assign o_side  = r_side[N];

endmodule
